// ----- hw/rtl/gtg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants
// Register indexes, fixed-point constants, arctangent table.
// ----------------------------------------------------------------------------
package gtg_pkg;

  localparam int CordicIterationsDefault = 16;
  localparam int TableLen = 24;

  // CORDIC datapath widths
  localparam int XyW = 36;  // dx,dy (17b) scaled by 2^14, plus gain growth
  localparam int ZW  = 29;  // angle, 2^-24 rad units

  localparam logic signed [ZW-1:0] AngPi    = 29'sd52707179;
  localparam logic signed [ZW+1:0] AngTwoPi = 31'sd105414358;
  localparam logic [29:0] GainK = 30'd652032874;

  localparam logic [2:0] RegGoalX     = 3'd0;
  localparam logic [2:0] RegGoalY     = 3'd1;
  localparam logic [2:0] RegThreshold = 3'd2;
  localparam logic [2:0] RegTurnGain  = 3'd3;
  localparam logic [2:0] RegDriveGain = 3'd4;
  localparam logic [2:0] RegStopRad   = 3'd5;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = 29'sd13176795;
      5'd1: atan_lut = 29'sd7778716;
      5'd2: atan_lut = 29'sd4110060;
      5'd3: atan_lut = 29'sd2086331;
      5'd4: atan_lut = 29'sd1047214;
      5'd5: atan_lut = 29'sd524117;
      5'd6: atan_lut = 29'sd262123;
      5'd7: atan_lut = 29'sd131069;
      5'd8: atan_lut = 29'sd65536;
      5'd9: atan_lut = 29'sd32768;
      5'd10: atan_lut = 29'sd16384;
      5'd11: atan_lut = 29'sd8192;
      5'd12: atan_lut = 29'sd4096;
      5'd13: atan_lut = 29'sd2048;
      5'd14: atan_lut = 29'sd1024;
      5'd15: atan_lut = 29'sd512;
      5'd16: atan_lut = 29'sd256;
      5'd17: atan_lut = 29'sd128;
      5'd18: atan_lut = 29'sd64;
      5'd19: atan_lut = 29'sd32;
      5'd20: atan_lut = 29'sd16;
      5'd21: atan_lut = 29'sd8;
      5'd22: atan_lut = 29'sd4;
      5'd23: atan_lut = 29'sd2;
      default: atan_lut = '0;
    endcase
  endfunction

  // Sideband carried beside the CORDIC stages
  typedef struct packed {
    logic               valid;
    logic               zero;     // robot sits on the goal
    logic signed [15:0] heading;
  } side_t;

endpackage

// ----- hw/rtl/gtg_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_cordic: pipelined vectoring CORDIC
// One rotation step per register stage; takes one vector per cycle.
// ----------------------------------------------------------------------------
module gtg_cordic #(
  parameter int CORDIC_ITERATIONS = gtg_pkg::CordicIterationsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gtg_pkg::side_t                    side_in,
  input  logic signed [gtg_pkg::XyW-1:0]    x_in,
  input  logic signed [gtg_pkg::XyW-1:0]    y_in,
  input  logic signed [gtg_pkg::ZW-1:0]     z_in,
  output gtg_pkg::side_t                    side_out,
  output logic signed [gtg_pkg::XyW-1:0]    x_out,
  output logic signed [gtg_pkg::ZW-1:0]     z_out
);

  localparam int N = CORDIC_ITERATIONS;

  gtg_pkg::side_t                 side [N+1];
  logic signed [gtg_pkg::XyW-1:0] x    [N+1];
  logic signed [gtg_pkg::XyW-1:0] y    [N+1];
  logic signed [gtg_pkg::ZW-1:0]  z    [N+1];

  assign side[0] = side_in;
  assign x[0] = x_in;
  assign y[0] = y_in;
  assign z[0] = z_in;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [gtg_pkg::XyW-1:0] xs, ys;
    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        side[i+1].valid <= 1'b0;
      end else begin
        side[i+1].valid <= side[i].valid;
      end
      side[i+1].zero    <= side[i].zero;
      side[i+1].heading <= side[i].heading;
      if (y[i] < 0) begin
        x[i+1] <= x[i] - ys;
        y[i+1] <= y[i] + xs;
        z[i+1] <= z[i] - gtg_pkg::atan_lut(5'(i));
      end else begin
        x[i+1] <= x[i] + ys;
        y[i+1] <= y[i] - xs;
        z[i+1] <= z[i] + gtg_pkg::atan_lut(5'(i));
      end
    end
  end

  assign side_out = side[N];
  assign x_out = x[N];
  assign z_out = z[N];

endmodule

// ----- hw/rtl/go_to_goal_heading_first_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_heading_first_controller
// Pose sample in, velocity command out; turns toward the goal before driving.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// pose      in         start / busy         pose_x, pose_y, pose_heading
// command   out        done (1-cycle beat)  linear_velocity, angular_velocity,
//                                           turning_mode, arrived
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Throughput: one beat accepted per clock; busy is tied low. Pipeline: one
// input stage (vector set-up), one per CORDIC step, then four stages for
// distance product/raw error, wrap and round, gain products and
// saturation. The CORDIC pipeline sets the latency.
// Reset: synchronous; clears valid bits and loads register reset values.
// Stalls: the receiver cannot stall, so nothing backs up; cfg_ready is high.
// ----------------------------------------------------------------------------
module go_to_goal_heading_first_controller #(
  parameter int CORDIC_ITERATIONS = gtg_pkg::CordicIterationsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] pose_x,
  input  logic signed [15:0] pose_y,
  input  logic signed [15:0] pose_heading,
  output logic               done,
  output logic [14:0]        linear_velocity,
  output logic signed [15:0] angular_velocity,
  output logic               turning_mode,
  output logic               arrived,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int XyW = gtg_pkg::XyW;
  localparam int ZW  = gtg_pkg::ZW;

  // Config registers
  logic signed [15:0] goal_x, goal_y;
  logic [14:0] heading_threshold, stop_radius;
  logic [15:0] turn_gain, drive_gain;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x            <= '0;
      goal_y            <= '0;
      heading_threshold <= 15'd573;
      turn_gain         <= 16'd1638;
      drive_gain        <= 16'd8192;
      stop_radius       <= 15'd2048;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gtg_pkg::RegGoalX:     goal_x <= cfg_data;
        gtg_pkg::RegGoalY:     goal_y <= cfg_data;
        gtg_pkg::RegThreshold: heading_threshold <= cfg_data[14:0];
        gtg_pkg::RegTurnGain:  turn_gain <= cfg_data;
        gtg_pkg::RegDriveGain: drive_gain <= cfg_data;
        gtg_pkg::RegStopRad:   stop_radius <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Stage 0: goal vector, half-plane fold
  logic signed [16:0] dx, dy;
  assign dx = 17'(goal_x) - 17'(pose_x);
  assign dy = 17'(goal_y) - 17'(pose_y);

  gtg_pkg::side_t           s0;
  logic signed [XyW-1:0]    x0, y0;
  logic signed [ZW-1:0]     z0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
    end else begin
      s0.valid <= start && !busy;
    end
    s0.zero    <= (dx == 0) && (dy == 0);
    s0.heading <= pose_heading;
    if (dx < 0) begin
      x0 <= -(XyW'(dx) <<< 14);
      y0 <= -(XyW'(dy) <<< 14);
      z0 <= (dy >= 0) ? gtg_pkg::AngPi : -gtg_pkg::AngPi;
    end else begin
      x0 <= XyW'(dx) <<< 14;
      y0 <= XyW'(dy) <<< 14;
      z0 <= '0;
    end
  end

  gtg_pkg::side_t        sc;
  logic signed [XyW-1:0] xc;
  logic signed [ZW-1:0]  zc;

  gtg_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk(clk), .rst(rst),
    .side_in(s0), .x_in(x0), .y_in(y0), .z_in(z0),
    .side_out(sc), .x_out(xc), .z_out(zc)
  );

  // Stage A: distance product, raw heading error
  logic [XyW-1:0] xpos;
  assign xpos = (xc < 0 || sc.zero) ? '0 : xc;

  logic         va;
  logic [65:0]  dprod;
  logic signed [ZW+2:0] err_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= sc.valid;
    end
    dprod <= 66'(xpos) * 66'(gtg_pkg::GainK);
    err_a <= (sc.zero ? 32'sd0 : 32'(zc)) - (32'(sc.heading) <<< 12);
  end

  // Stage B: wrap into (-pi, pi], round to Q3.12, distance round
  // err spans about +-3.6 pi, so the wrap takes at most two 2*pi steps.
  logic signed [ZW+2:0] w;
  always_comb begin
    w = err_a;
    for (int k = 0; k < 3; k++) begin
      if (w > 32'(gtg_pkg::AngPi)) w = w - 32'(gtg_pkg::AngTwoPi);
      else if (w <= -32'(gtg_pkg::AngPi)) w = w + 32'(gtg_pkg::AngTwoPi);
    end
  end

  logic               vb;
  logic signed [16:0] e12;
  logic [21:0]        goal_dist;

  logic signed [ZW+2:0] w_r;
  assign w_r = w + 32'sd2048;

  logic [65:0] dsum;
  assign dsum = dprod + (66'd1 << 43);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    e12       <= 17'(w_r >>> 12);
    goal_dist <= dsum[65:44];
  end

  // Stage C: gain products, heading-threshold and stop-radius compares
  logic               vc, turn_c, arr_c;
  logic signed [34:0] aprod;
  logic [37:0]        lprod;
  logic [16:0]        mag;
  assign mag = (e12 < 0) ? 17'(-e12) : 17'(e12);

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
    turn_c <= mag > 17'(heading_threshold);
    arr_c  <= goal_dist <= 22'(stop_radius);
    aprod  <= 35'(e12) * $signed({19'd0, turn_gain});
    lprod  <= 38'(goal_dist) * 38'(drive_gain);
  end

  // Stage D: round, saturate, select
  logic signed [34:0] ar;
  logic [37:0]        lr;
  logic signed [22:0] ash;
  logic [25:0]        lsh;
  assign ar  = aprod + 35'sd2048;
  assign lr  = lprod + 38'd2048;
  assign ash = 23'(ar >>> 12);
  assign lsh = lr[37:12];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vc;
    end
    turning_mode <= turn_c;
    arrived      <= arr_c;
    if (turn_c) begin
      linear_velocity <= '0;
      if (ash > 23'sd32767) angular_velocity <= 16'sh7fff;
      else if (ash < -23'sd32768) angular_velocity <= 16'sh8000;
      else angular_velocity <= ash[15:0];
    end else begin
      angular_velocity <= '0;
      linear_velocity <= (lsh > 26'd32767) ? 15'h7fff : lsh[14:0];
    end
  end

  // Checks
  a_busy_low: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_drive_no_turn: assert property (@(posedge clk) disable iff (rst)
    done && !turning_mode |-> angular_velocity == 0)
    else $error("turn while driving");
  a_turn_no_drive: assert property (@(posedge clk) disable iff (rst)
    done && turning_mode |-> linear_velocity == 0)
    else $error("drive while turning");
  a_no_early_done: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("done right after reset");

endmodule

// ----- test/gtg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_checker: command predictor and scoreboard
// Watches pose beats, config writes and command beats; predicts each command
// with a bit-true CORDIC model and compares it field by field.
// ----------------------------------------------------------------------------
module gtg_checker #(
  parameter int CORDIC_ITERATIONS = gtg_pkg::CordicIterationsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] pose_x,
  input  logic signed [15:0] pose_y,
  input  logic signed [15:0] pose_heading,
  input  logic               done,
  input  logic [14:0]        linear_velocity,
  input  logic signed [15:0] angular_velocity,
  input  logic               turning_mode,
  input  logic               arrived,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [14:0]        lin;
    logic signed [15:0] ang;
    logic               turn;
    logic               arr;
  } cmd_t;

  cmd_t cmd_q[$];

  logic signed [15:0] goal_x, goal_y;
  logic [14:0] thresh, stop_rad;
  logic [15:0] turn_k, drive_k;

  localparam longint TwoPi = 105414358;
  localparam longint Pi = 52707179;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_val(int i);
    longint t[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                      262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                      1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    return t[i];
  endfunction

  function automatic cmd_t steer(logic signed [15:0] px, logic signed [15:0] py,
                                 logic signed [15:0] hd);
    longint dx, dy, x, y, z, xs, ys, err, e12, mag, ang;
    longint unsigned goal_dist, lin;
    cmd_t c;
    dx = longint'(goal_x) - longint'(px);
    dy = longint'(goal_y) - longint'(py);
    z = 0;
    goal_dist = 0;
    if (dx != 0 || dy != 0) begin
      x = dx * 16384;
      y = dy * 16384;
      if (x < 0) begin
        z = (y >= 0) ? Pi : -Pi;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
        xs = fshr(x, i);
        ys = fshr(y, i);
        if (y < 0) begin
          x = x - ys; y = y + xs; z = z - atan_val(i);
        end else begin
          x = x + ys; y = y - xs; z = z + atan_val(i);
        end
      end
      if (x < 0) x = 0;
      goal_dist = (longint'(x) * 652032874 + (64'd1 << 43)) >> 44;
    end
    err = z - longint'(hd) * 4096;
    while (err > Pi) err -= TwoPi;
    while (err <= -Pi) err += TwoPi;
    e12 = fshr(err + 2048, 12);
    mag = (e12 < 0) ? -e12 : e12;
    c = '0;
    c.turn = (mag > longint'(thresh));
    if (c.turn) begin
      ang = fshr(e12 * longint'(turn_k) + 2048, 12);
      if (ang > 32767) ang = 32767;
      if (ang < -32768) ang = -32768;
      c.ang = ang[15:0];
    end else begin
      lin = (goal_dist * drive_k + 2048) >> 12;
      if (lin > 32767) lin = 32767;
      c.lin = lin[14:0];
    end
    c.arr = (goal_dist <= stop_rad);
    return c;
  endfunction

  always_ff @(posedge clk) begin
    cmd_t got, want;
    if (rst) begin
      goal_x <= '0; goal_y <= '0; thresh <= 15'd573;
      turn_k <= 16'd1638; drive_k <= 16'd8192; stop_rad <= 15'd2048;
      cmd_q.delete();
      fail_count <= 0;
    end else begin
      // prediction uses registers before this edge's write; writes must happen
      // only while idle (not enforced here), so order does not matter
      if (start && !busy) cmd_q.push_back(steer(pose_x, pose_y, pose_heading));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gtg_pkg::RegGoalX:     goal_x <= cfg_data;
          gtg_pkg::RegGoalY:     goal_y <= cfg_data;
          gtg_pkg::RegThreshold: thresh <= cfg_data[14:0];
          gtg_pkg::RegTurnGain:  turn_k <= cfg_data;
          gtg_pkg::RegDriveGain: drive_k <= cfg_data;
          gtg_pkg::RegStopRad:   stop_rad <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (done) begin
        got = '{linear_velocity, angular_velocity, turning_mode, arrived};
        if (cmd_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected command beat %p", got);
        end else begin
          want = cmd_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("command mismatch: exp %p got %p", want, got);
          end
        end
      end
    end
    pending <= cmd_q.size();
  end
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: go-to-goal controller testbench
// Drives pose beats and register writes; the checker predicts and scores.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int Latency = gtg_pkg::CordicIterationsDefault + 5;
  localparam longint Limit = 400000;

  logic clk, rst;
  logic start, busy, done, turning_mode, arrived, cfg_valid, cfg_ready;
  logic signed [15:0] pose_x, pose_y, pose_heading, angular_velocity;
  logic [14:0] linear_velocity;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  int fail_count, pending;
  longint cycles;

  go_to_goal_heading_first_controller dut (.*);
  gtg_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > Limit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // send one pose beat; start stays high across back-to-back beats
  task automatic send_pose(logic [15:0] x, logic [15:0] y, logic [15:0] h, bit gaps);
    int g;
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      g = $urandom_range(1, 15);
      repeat (g) @(posedge clk);
    end
    pose_x <= x;
    pose_y <= y;
    pose_heading <= h;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  // pose near the goal one time in three so arrival and small vectors show up
  task automatic rand_pose(logic [15:0] gx, logic [15:0] gy, bit gaps);
    logic [15:0] x, y;
    if ($urandom_range(0, 2) == 0) begin
      x = gx + 16'($signed($urandom_range(0, 8191)) - 4096);
      y = gy + 16'($signed($urandom_range(0, 8191)) - 4096);
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
    end
    send_pose(x, y, 16'($urandom), gaps);
  endtask

  logic [15:0] gx, gy;

  initial begin
    rst = 1'b1;
    start = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    pose_x = '0; pose_y = '0; pose_heading = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset values, at goal, axes, extremes, heading out of range
    send_pose(16'h0000, 16'h0000, 16'h0000, 0);
    send_pose(16'h0000, 16'h0000, 16'h7FFF, 0);
    send_pose(16'h8000, 16'h0000, 16'h0000, 0);   // goal ahead on +x
    send_pose(16'h7FFF, 16'h0000, 16'h0000, 0);   // goal behind, dy = 0
    send_pose(16'h7FFF, 16'h0001, 16'h0000, 0);   // goal behind, dy < 0
    send_pose(16'h0000, 16'h8000, 16'h8000, 0);
    send_pose(16'h0000, 16'h7FFF, 16'h3000, 0);
    send_pose(16'h8000, 16'h8000, 16'h0C90, 0);
    send_pose(16'h7FFF, 16'h7FFF, 16'hF370, 0);
    send_pose(16'h0400, 16'h0000, 16'h0000, 0);   // within stop radius
    send_pose(16'h0800, 16'h0000, 16'h0000, 0);   // exactly on the radius
    drain();
    write_reg(gtg_pkg::RegGoalX, 16'h7FFF);
    write_reg(gtg_pkg::RegGoalY, 16'h8000);
    write_reg(gtg_pkg::RegThreshold, 16'hFFFF);   // top bit dropped
    write_reg(gtg_pkg::RegTurnGain, 16'hFFFF);
    write_reg(gtg_pkg::RegDriveGain, 16'hFFFF);
    write_reg(gtg_pkg::RegStopRad, 16'h7FFF);
    write_reg(3'd7, 16'h1234);                    // unused index, ignored
    send_pose(16'h8000, 16'h7FFF, 16'h8000, 0);
    send_pose(16'h7FFF, 16'h8000, 16'h0000, 0);
    send_pose(16'h0000, 16'h0000, 16'h7FFF, 0);
    drain();
    write_reg(gtg_pkg::RegThreshold, 16'h0000);
    send_pose(16'h8000, 16'h7FFF, 16'h4000, 0);
    send_pose(16'h0000, 16'h0000, 16'hC000, 0);
    drain();

    // random phases with random register settings, extremes mixed in
    for (int ph = 0; ph < 10; ph++) begin
      gx = (ph % 3 == 0) ? 16'h8000 : 16'($urandom);
      gy = (ph % 3 == 1) ? 16'h7FFF : 16'($urandom);
      write_reg(gtg_pkg::RegGoalX, gx);
      write_reg(gtg_pkg::RegGoalY, gy);
      write_reg(gtg_pkg::RegThreshold,
                (ph % 4 == 0) ? 16'h0 : 16'($urandom_range(0, 13000)));
      write_reg(gtg_pkg::RegTurnGain, (ph % 5 == 0) ? 16'hFFFF : 16'($urandom));
      write_reg(gtg_pkg::RegDriveGain, (ph % 5 == 1) ? 16'h0 : 16'($urandom));
      write_reg(gtg_pkg::RegStopRad, 16'($urandom));
      for (int n = 0; n < 70; n++) rand_pose(gx, gy, ph < 8);
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
